FILE: rtl/core/ppp_pkg.sv
// ----------------------------------------------------------------------------
// ppp_pkg: shared definitions for the perspective point projection block
// Fixed-point widths, pipeline depths, operation and register codes.
// ----------------------------------------------------------------------------
package ppp_pkg;

	localparam int COORD_W   = 32;  // width of coordinates, coefficients and results
	localparam int FRAC_BITS = 16;  // fractional bits of every fixed-point value
	localparam int CLIP_W    = 51;  // signed width of a clip-space sum
	localparam int MAG_W     = 50;  // magnitude width of a clip value
	localparam int Q_W       = 50;  // quotient bits produced by the divider
	localparam int CAP_EXP   = 49;  // ndc magnitude is held at 2**CAP_EXP
	localparam int CAP_SH    = CAP_EXP - FRAC_BITS;
	localparam int HALF_W    = 13;  // width of half the screen size
	localparam int DIM_W     = 14;
	localparam int NEAR_W    = 17;
	localparam int ADDR_W    = 4;

	localparam int CLIP_LAT  = 3;
	localparam int DIV_LAT   = Q_W + 2;
	localparam int PIPE_LAT  = CLIP_LAT + 1 + DIV_LAT + 2;

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_PROJECT = 1'b1
	} op_t;

	localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [1:0] REG_NEAR_W_LIMIT  = 2'd2;

	// Side information that travels beside the quotients.
	typedef struct packed {
		logic valid;
		logic vis;
	} ppp_tag_t;

endpackage

FILE: rtl/core/ppp_clip.sv
// ----------------------------------------------------------------------------
// ppp_clip: matrix store and clip-space transform
// Holds the 4x4 matrix and forms clip x, y and w in three stages.
// ----------------------------------------------------------------------------
module ppp_clip
	import ppp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [3:0]               wr_idx,
	input  logic [COORD_W-1:0]       wr_data,
	input  logic                     in_valid,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic signed [COORD_W-1:0] pos_z,
	output logic                     out_valid,
	output logic signed [CLIP_W-1:0] clip_x,
	output logic signed [CLIP_W-1:0] clip_y,
	output logic signed [CLIP_W-1:0] clip_w
);

	logic [COORD_W-1:0] matrix_q [16];

	logic                      valid_s1, valid_s2, valid_s3;
	logic signed [COORD_W-1:0] pos_s1 [3];
	logic signed [2*COORD_W-1:0] prod_s2 [3][3];
	logic signed [COORD_W-1:0] off_s2 [3];
	logic signed [CLIP_W-1:0]  clip_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) matrix_q[i] <= '0;
		end else if (wr_en) begin
			matrix_q[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		pos_s1[0] <= pos_x;
		pos_s1[1] <= pos_y;
		pos_s1[2] <= pos_z;
	end

	// Rows 0, 1 and 3 of the matrix; clip z is not needed.
	for (genvar r = 0; r < 3; r++) begin : g_row
		localparam int ROW = (r == 2) ? 3 : r;
		logic signed [2*COORD_W-1:0] sum;

		always_ff @(posedge clk) begin
			for (int c = 0; c < 3; c++) begin
				prod_s2[r][c] <= pos_s1[c] * $signed(matrix_q[ROW*4+c]);
			end
			off_s2[r] <= $signed(matrix_q[ROW*4+3]);
		end

		// Arithmetic shifts round each product toward minus infinity.
		assign sum = off_s2[r] + (prod_s2[r][0] >>> FRAC_BITS)
			+ (prod_s2[r][1] >>> FRAC_BITS) + (prod_s2[r][2] >>> FRAC_BITS);

		always_ff @(posedge clk) begin
			clip_s3[r] <= sum[CLIP_W-1:0];
		end
	end

	assign out_valid = valid_s3;
	assign clip_x    = clip_s3[0];
	assign clip_y    = clip_s3[1];
	assign clip_w    = clip_s3[2];

endmodule

FILE: rtl/core/ppp_divider.sv
// ----------------------------------------------------------------------------
// ppp_divider: pipelined two-lane fixed-point divider
// Restoring division, one quotient bit per stage, with magnitude capping.
// ----------------------------------------------------------------------------
module ppp_divider
	import ppp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  ppp_tag_t                 in_tag,
	input  logic [1:0]               in_neg,
	input  logic [MAG_W-1:0]         num_x,
	input  logic [MAG_W-1:0]         num_y,
	input  logic [MAG_W-1:0]         den,
	output ppp_tag_t                 out_tag,
	output logic signed [CLIP_W-1:0] ndc_x,
	output logic signed [CLIP_W-1:0] ndc_y
);

	ppp_tag_t           tag_s [Q_W+1];
	logic [MAG_W-1:0]   den_s [Q_W+1];
	logic [MAG_W-1:0]   rem_s [2][Q_W+1];
	logic [Q_W-1:0]     low_s [2][Q_W+1];
	logic [Q_W-1:0]     quo_s [2][Q_W+1];
	logic               cap_s [2][Q_W+1];
	logic               neg_s [2][Q_W+1];
	logic [MAG_W-1:0]   num [2];
	ppp_tag_t           tag_q;
	logic signed [CLIP_W-1:0] ndc_q [2];

	assign num[0] = num_x;
	assign num[1] = num_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= Q_W; k++) tag_s[k] <= '0;
			tag_q <= '0;
		end else begin
			tag_s[0] <= in_tag;
			for (int k = 0; k < Q_W; k++) tag_s[k+1] <= tag_s[k];
			tag_q <= tag_s[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		den_s[0] <= den;
		for (int k = 0; k < Q_W; k++) den_s[k+1] <= den_s[k];
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic [MAG_W-1:0] mag;

		// The dividend is num shifted up by the fraction; its top bits seed the
		// remainder, and a quotient of 2**CAP_SH or more in whole units is capped.
		always_ff @(posedge clk) begin
			rem_s[l][0] <= num[l] >> (Q_W - FRAC_BITS);
			low_s[l][0] <= {num[l][Q_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
			quo_s[l][0] <= '0;
			cap_s[l][0] <= {{CAP_SH{1'b0}}, num[l]} >= {den, {CAP_SH{1'b0}}};
			neg_s[l][0] <= in_neg[l];
		end

		for (genvar k = 0; k < Q_W; k++) begin : g_stage
			logic [MAG_W:0] trial;
			logic [MAG_W:0] diff;
			logic           take;

			assign trial = {rem_s[l][k], low_s[l][k][Q_W-1]};
			assign diff  = trial - {1'b0, den_s[k]};
			assign take  = trial >= {1'b0, den_s[k]};

			always_ff @(posedge clk) begin
				rem_s[l][k+1] <= take ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
				low_s[l][k+1] <= {low_s[l][k][Q_W-2:0], 1'b0};
				quo_s[l][k+1] <= {quo_s[l][k][Q_W-2:0], take};
				cap_s[l][k+1] <= cap_s[l][k];
				neg_s[l][k+1] <= neg_s[l][k];
			end
		end

		assign mag = cap_s[l][Q_W] ? (MAG_W'(1) << CAP_EXP) : quo_s[l][Q_W];

		always_ff @(posedge clk) begin
			ndc_q[l] <= neg_s[l][Q_W] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

	assign out_tag = tag_q;
	assign ndc_x   = ndc_q[0];
	assign ndc_y   = ndc_q[1];

endmodule

FILE: rtl/core/ppp_screen.sv
// ----------------------------------------------------------------------------
// ppp_screen: viewport mapping and saturation
// Scales ndc by half the screen size, saturates, and drives the result word.
// ----------------------------------------------------------------------------
module ppp_screen
	import ppp_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  ppp_tag_t                  in_tag,
	input  logic signed [CLIP_W-1:0]  ndc_x,
	input  logic signed [CLIP_W-1:0]  ndc_y,
	input  logic [HALF_W-1:0]         half_w,
	input  logic [HALF_W-1:0]         half_h,
	output logic                      done,
	output logic                      visible,
	output logic signed [COORD_W-1:0] screen_x,
	output logic signed [COORD_W-1:0] screen_y
);

	localparam int PROD_W = CLIP_W + 1 + HALF_W + 1;
	localparam logic signed [CLIP_W:0]   ONE    = (CLIP_W+1)'(1) << FRAC_BITS;
	localparam logic signed [PROD_W-1:0] SAT_HI = (PROD_W'(1) << (COORD_W-1)) - PROD_W'(1);
	localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

	function automatic logic [COORD_W-1:0] saturate(input logic signed [PROD_W-1:0] v);
		logic [COORD_W-1:0] res;
		if (v > SAT_HI) res = SAT_HI[COORD_W-1:0];
		else if (v < SAT_LO) res = SAT_LO[COORD_W-1:0];
		else res = v[COORD_W-1:0];
		return res;
	endfunction

	logic signed [CLIP_W:0]   tx, ty;
	logic signed [PROD_W-1:0] px_s1, py_s1;
	ppp_tag_t                 tag_s1;
	logic                     done_q, vis_q;
	logic [COORD_W-1:0]       sx_q, sy_q;

	assign tx = $signed({ndc_x[CLIP_W-1], ndc_x}) + ONE;
	assign ty = ONE - $signed({ndc_y[CLIP_W-1], ndc_y});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			done_q <= 1'b0;
		end else begin
			tag_s1 <= in_tag;
			done_q <= tag_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= tx * $signed({1'b0, half_w});
		py_s1 <= ty * $signed({1'b0, half_h});
		vis_q <= tag_s1.vis;
		sx_q  <= tag_s1.vis ? saturate(px_s1) : '0;
		sy_q  <= tag_s1.vis ? saturate(py_s1) : '0;
	end

	assign done     = done_q;
	assign visible  = vis_q;
	assign screen_x = sx_q;
	assign screen_y = sy_q;

endmodule

FILE: rtl/core/perspective_point_projection.sv
// ----------------------------------------------------------------------------
// perspective_point_projection: 3-D point to screen projection pipeline
// Stored 4x4 matrix, clip transform, near test, divide and viewport map.
// ----------------------------------------------------------------------------
// Usage: a command word is taken at each clock edge where start is high and
// busy is low. busy never rises, so one word can be taken in every cycle.
// A word with operation = load writes entry_value into the row-major matrix
// entry entry_index and produces nothing; the write is seen by any project
// word taken at a later edge. A word with operation = project carries a
// Q16.16 point and produces exactly one result word: done is high for one
// cycle with visible, screen_x and screen_y. The path runs through three
// clip stages, a near test stage, the divider (an entry stage, one quotient
// bit per stage over 50 stages and an output stage) and two viewport
// stages. Results leave in command order.
// The receiver cannot stall the pipeline; a result must be taken in the
// cycle in which done is high. The APB port sets screen size and the near
// limit; the user must write it only while no project word is in flight,
// as the block itself does not enforce this. Reset clears the matrix to
// zero, restores the register defaults and empties the pipeline at once.
// ----------------------------------------------------------------------------
module perspective_point_projection
	import ppp_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	// Command channel.
	input  logic                      start,
	output logic                      busy,
	input  logic                      operation,
	input  logic [3:0]                entry_index,
	input  logic signed [COORD_W-1:0] entry_value,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic signed [COORD_W-1:0] pos_z,
	// Result channel.
	output logic                      done,
	output logic                      visible,
	output logic signed [COORD_W-1:0] screen_x,
	output logic signed [COORD_W-1:0] screen_y,
	// Configuration port.
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	logic [DIM_W-1:0]  screen_width_q;
	logic [DIM_W-1:0]  screen_height_q;
	logic [NEAR_W-1:0] near_w_limit_q;
	logic              cfg_wr;
	logic              accept;
	logic              load_wr;
	logic              proj_in;

	assign busy    = 1'b0;
	assign pready  = 1'b1;
	assign accept  = start && !busy;
	assign load_wr = accept && (op_t'(operation) == OP_LOAD);
	assign proj_in = accept && (op_t'(operation) == OP_PROJECT);
	assign cfg_wr  = psel && penable && pwrite && pready;

	// Configuration registers; a write to an unknown index is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= DIM_W'(1920);
			screen_height_q <= DIM_W'(1080);
			near_w_limit_q  <= NEAR_W'(6554);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_SCREEN_WIDTH:  screen_width_q  <= pwdata[DIM_W-1:0];
				REG_SCREEN_HEIGHT: screen_height_q <= pwdata[DIM_W-1:0];
				REG_NEAR_W_LIMIT:  near_w_limit_q  <= pwdata[NEAR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SCREEN_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, screen_width_q};
			REG_SCREEN_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, screen_height_q};
			REG_NEAR_W_LIMIT:  prdata = {{(32-NEAR_W){1'b0}}, near_w_limit_q};
			default:           prdata = '0;
		endcase
	end

	// Clip-space transform: three stages.
	logic                     clip_valid;
	logic signed [CLIP_W-1:0] clip_x, clip_y, clip_w;

	ppp_clip u_clip (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (load_wr),
		.wr_idx    (entry_index),
		.wr_data   (entry_value),
		.in_valid  (proj_in),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.out_valid (clip_valid),
		.clip_x    (clip_x),
		.clip_y    (clip_y),
		.clip_w    (clip_w)
	);

	// Near test and sign/magnitude split ahead of the divider. A point is
	// visible only if clip w reaches the limit and is strictly positive, so
	// the divider never sees a zero divisor on a visible point.
	logic signed [CLIP_W-1:0] near_ext, abs_x, abs_y;
	ppp_tag_t                 tag_s4;
	logic [1:0]               neg_s4;
	logic [MAG_W-1:0]         num_x_s4, num_y_s4, den_s4;

	assign near_ext = $signed({{(CLIP_W-NEAR_W){1'b0}}, near_w_limit_q});
	assign abs_x    = clip_x[CLIP_W-1] ? -clip_x : clip_x;
	assign abs_y    = clip_y[CLIP_W-1] ? -clip_y : clip_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s4 <= '0;
		end else begin
			tag_s4.valid <= clip_valid;
			tag_s4.vis   <= (clip_w >= near_ext) && (clip_w > 0);
		end
	end

	always_ff @(posedge clk) begin
		neg_s4   <= {clip_y[CLIP_W-1], clip_x[CLIP_W-1]};
		num_x_s4 <= abs_x[MAG_W-1:0];
		num_y_s4 <= abs_y[MAG_W-1:0];
		den_s4   <= clip_w[MAG_W-1:0];
	end

	// Pipelined division of clip x and y by clip w.
	ppp_tag_t                 div_tag;
	logic signed [CLIP_W-1:0] ndc_x, ndc_y;

	ppp_divider u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_tag  (tag_s4),
		.in_neg  (neg_s4),
		.num_x   (num_x_s4),
		.num_y   (num_y_s4),
		.den     (den_s4),
		.out_tag (div_tag),
		.ndc_x   (ndc_x),
		.ndc_y   (ndc_y)
	);

	// Viewport map with integer-halved screen size.
	ppp_screen u_screen (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_tag   (div_tag),
		.ndc_x    (ndc_x),
		.ndc_y    (ndc_y),
		.half_w   (screen_width_q[DIM_W-1:1]),
		.half_h   (screen_height_q[DIM_W-1:1]),
		.done     (done),
		.visible  (visible),
		.screen_x (screen_x),
		.screen_y (screen_y)
	);

	// Every project word yields its result after the fixed latency.
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		proj_in |-> ##PIPE_LAT done)
		else $error("project word without result at fixed latency");

	// No result appears without a project word at the matching edge.
	a_latency_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(proj_in, PIPE_LAT))
		else $error("result word without a matching project word");

	// A rejected point reports zero coordinates.
	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !visible) |-> (screen_x == 0 && screen_y == 0))
		else $error("hidden point with nonzero coordinates");

endmodule

FILE: verif/ppp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_checker: result predictor and scoreboard for point projection
// Watches the command, result and configuration channels, keeps its own copy
// of the matrix and registers, and compares every result word in order.
// ----------------------------------------------------------------------------
module ppp_checker
	import ppp_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic                      operation,
	input  logic [3:0]                entry_index,
	input  logic signed [COORD_W-1:0] entry_value,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic signed [COORD_W-1:0] pos_z,
	input  logic                      done,
	input  logic                      visible,
	input  logic signed [COORD_W-1:0] screen_x,
	input  logic signed [COORD_W-1:0] screen_y,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [31:0]               pwdata,
	input  logic                      pready,
	output int                        fail_count,
	output int                        pending,
	output int                        seen_count
);

	typedef struct packed {
		logic        vis;
		logic [31:0] sx;
		logic [31:0] sy;
	} screen_word_t;

	logic signed [31:0] matrix [16];
	logic [13:0]        width_reg;
	logic [13:0]        height_reg;
	logic [16:0]        near_reg;
	screen_word_t       expected_q[$];

	function automatic longint floor_q(longint v);
		return v >>> FRAC_BITS;
	endfunction

	function automatic longint clip_of(int row, longint x, longint y, longint z);
		longint acc;
		acc = longint'(matrix[row*4+3]);
		acc += floor_q(x * longint'(matrix[row*4+0]));
		acc += floor_q(y * longint'(matrix[row*4+1]));
		acc += floor_q(z * longint'(matrix[row*4+2]));
		return acc;
	endfunction

	function automatic longint ndc_of(longint num, longint den);
		logic          neg;
		longint unsigned a, q, r, mag;
		neg = num < 0;
		a = neg ? -num : num;
		q = a / den;
		r = a % den;
		if (q >= (64'd1 << CAP_SH)) begin
			mag = 64'd1 << CAP_EXP;
		end else begin
			mag = q;
			for (int i = 0; i < FRAC_BITS; i++) begin
				r = r << 1;
				mag = mag << 1;
				if (r >= den) begin
					r -= den;
					mag |= 1;
				end
			end
		end
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'h7fffffff;
		if (v < -64'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic screen_word_t project_point(longint x, longint y, longint z);
		screen_word_t w;
		longint cx, cy, cw, nx, ny, hw, hh;
		cx = clip_of(0, x, y, z);
		cy = clip_of(1, x, y, z);
		cw = clip_of(3, x, y, z);
		w = '0;
		if (cw < longint'(near_reg) || cw <= 0) return w;
		nx = ndc_of(cx, cw);
		ny = ndc_of(cy, cw);
		hw = longint'(width_reg >> 1);
		hh = longint'(height_reg >> 1);
		w.vis = 1'b1;
		w.sx = clamp32(hw * (nx + (64'sd1 <<< FRAC_BITS)));
		w.sy = clamp32(hh * ((64'sd1 <<< FRAC_BITS) - ny));
		return w;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		screen_word_t exp_w;
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) matrix[i] <= '0;
			width_reg  <= 14'd1920;
			height_reg <= 14'd1080;
			near_reg   <= 17'd6554;
			expected_q.delete();
			fail_count <= 0;
			seen_count <= 0;
		end else begin
			// Results are compared before this edge's command is queued.
			if (done) begin
				seen_count <= seen_count + 1;
				if (expected_q.size() == 0) begin
					$display("%0t: result with none expected: vis=%0b x=%h y=%h",
						$time, visible, screen_x, screen_y);
					fail_count <= fail_count + 1;
				end else begin
					exp_w = expected_q.pop_front();
					if (exp_w.vis !== visible || exp_w.sx !== screen_x ||
					    exp_w.sy !== screen_y) begin
						$display("%0t: mismatch expected vis=%0b x=%h y=%h actual vis=%0b x=%h y=%h",
							$time, exp_w.vis, exp_w.sx, exp_w.sy, visible, screen_x, screen_y);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy) begin
				if (op_t'(operation) == OP_LOAD)
					matrix[entry_index] <= entry_value;
				else
					expected_q.push_back(project_point(pos_x, pos_y, pos_z));
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_SCREEN_WIDTH:  width_reg  <= pwdata[13:0];
					REG_SCREEN_HEIGHT: height_reg <= pwdata[13:0];
					REG_NEAR_W_LIMIT:  near_reg   <= pwdata[16:0];
					default: ;
				endcase
			end
		end
	end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the perspective point projection block
// Drives matrix loads, projected points and register writes with random
// gaps; the checker predicts each result word and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
	import ppp_pkg::*;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	logic                      operation = 1'b0;
	logic [3:0]                entry_index = '0;
	logic signed [COORD_W-1:0] entry_value = '0;
	logic signed [COORD_W-1:0] pos_x = '0;
	logic signed [COORD_W-1:0] pos_y = '0;
	logic signed [COORD_W-1:0] pos_z = '0;
	logic                      done;
	logic                      visible;
	logic signed [COORD_W-1:0] screen_x;
	logic signed [COORD_W-1:0] screen_y;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [ADDR_W-1:0]         paddr = '0;
	logic [31:0]               pwdata = '0;
	logic [31:0]               prdata;
	logic                      pready;
	int                        fail_count;
	int                        pending;
	int                        seen_count;
	int                        word_count = 0;

	localparam int ONE = 1 << FRAC_BITS;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	perspective_point_projection u_top (.*);

	ppp_checker u_chk (.*);

	// Hard stop; the slowest legal run is far shorter than this.
	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

	// Random gap before a word: mostly none or short, now and then long.
	// start drops only when a gap follows, so words can run back to back.
	task automatic idle_gap();
		int n;
		n = $urandom_range(0, 99);
		if (n < 50) n = 0;
		else if (n < 92) n = $urandom_range(1, 3);
		else n = $urandom_range(8, 40);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// Present one command word and hold it until the block takes it.
	task automatic send_word(logic op, logic [3:0] idx, logic [31:0] val,
	                         logic [31:0] x, logic [31:0] y, logic [31:0] z,
	                         bit gaps);
		if (gaps) idle_gap();
		start <= 1'b1;
		operation <= op;
		entry_index <= idx;
		entry_value <= val;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		do @(posedge clk); while (busy);
		@(negedge clk);
		word_count++;
	endtask

	task automatic load_entry(int idx, logic [31:0] val);
		send_word(OP_LOAD, idx[3:0], val, $urandom, $urandom, $urandom, 1'b1);
	endtask

	task automatic project(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		send_word(OP_PROJECT, 4'($urandom), $urandom, x, y, z, 1'b1);
	endtask

	// Drain: every expected word in, then the pipeline depth for safety.
	task automatic drain();
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (PIPE_LAT + 4) @(negedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Mostly a sane camera matrix with random jitter, sometimes fully random.
	task automatic random_matrix();
		bit wild;
		wild = ($urandom_range(0, 4) == 0);
		for (int i = 0; i < 16; i++) begin
			if (wild) load_entry(i, $urandom);
			else if (i == 0 || i == 5 || i == 10)
				load_entry(i, $urandom_range(ONE/4, 4*ONE));
			else if (i == 14)
				load_entry(i, $urandom_range(ONE/2, 2*ONE));
			else if (i == 15)
				load_entry(i, $urandom_range(0, ONE));
			else
				load_entry(i, $signed($urandom_range(0, ONE)) - ONE/2);
		end
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return $signed($urandom_range(0, 40*ONE)) - 20*ONE;
		endcase
	endfunction

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reset matrix is all zero, so w is zero and nothing is visible.
		project(32'h7fffffff, 32'h80000000, 32'h0);
		// Identity-like matrix with w taken from z.
		load_entry(0, ONE);
		load_entry(5, ONE);
		load_entry(14, ONE);
		project(0, 0, ONE);
		project(ONE/2, -ONE/2, ONE);
		project(0, 0, 32'h00000100);         // w below the near limit
		project(32'h7fffffff, 32'h80000000, 32'h00001999); // w just below the near limit, hidden
		project(32'h80000000, 32'h7fffffff, 32'h7fffffff);
		load_entry(15, 32'h80000000);        // extreme coefficients
		load_entry(3, 32'h7fffffff);
		project(32'hffffffff, 32'h0, 32'h7fffffff);
		drain();
		// Zero near limit, zero w, a one-pixel width and a zero height.
		reg_write(REG_NEAR_W_LIMIT, 32'h0);
		reg_write(REG_SCREEN_WIDTH, 32'h1);
		reg_write(REG_SCREEN_HEIGHT, 32'h0);
		load_entry(15, 0);
		load_entry(3, 0);
		project(ONE, ONE, 0);
		project(ONE, ONE, ONE);
		drain();
		reg_write(REG_NEAR_W_LIMIT, 32'h10000);
		reg_write(REG_SCREEN_WIDTH, 32'h3fff);
		reg_write(REG_SCREEN_HEIGHT, 32'h2000);
		project(ONE, -ONE, ONE);
		project(ONE/4, ONE/4, 2*ONE);
		drain();

		// Random phases, each with its own register setting.
		for (int ph = 0; ph < 8; ph++) begin
			reg_write(REG_SCREEN_WIDTH, (ph == 3) ? 32'h2000 : $urandom_range(0, 16383));
			reg_write(REG_SCREEN_HEIGHT, (ph == 5) ? 32'h1 : $urandom_range(0, 16383));
			reg_write(REG_NEAR_W_LIMIT, (ph == 2) ? 32'h1ffff : $urandom_range(0, 65536));
			random_matrix();
			for (int k = 0; k < 62; k++) begin
				if ($urandom_range(0, 19) == 0)
					load_entry($urandom_range(0, 15), $urandom);
				else if (ph == 6)
					send_word(OP_PROJECT, 4'($urandom), $urandom,
						rand_coord(), rand_coord(), rand_coord(), 1'b0);
				else
					project(rand_coord(), rand_coord(), rand_coord());
				// Hold off once per phase until every result is back.
				if (k == 25) begin
					start <= 1'b0;
					@(negedge clk);
					while (pending != 0) @(negedge clk);
				end
			end
			drain();
		end

		$display("Sent %0d command words over 8 random register settings;", word_count);
		$display("%0d results checked, loads and projections mixed back to back.",
			seen_count);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
